### src/pink_noise_shaping_filter_defines.svh
// Assertion macros shared by the pink noise filter checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PINK_NOISE_SHAPING_FILTER_DEFINES_SVH
`define PINK_NOISE_SHAPING_FILTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PNSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PNSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pnsf_pkg.sv
// Shared types, constants and arithmetic helpers for the pink noise filter.
// No dependencies; used by pnsf_ctrl, pnsf_datapath and the top level.
package pnsf_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int STATE_FRAC_BITS = 24;
    localparam int COEF_FRAC       = 30;
    localparam int OUT_FRAC        = 15;
    localparam int OUT_WIDTH       = 19;
    localparam int STATE_WIDTH     = 32;
    localparam int NUM_SECTIONS    = 6;
    localparam int SEC_IDX_W       = 3;
    localparam int PROD_WIDTH      = 2 * STATE_WIDTH;
    localparam int TERM_WIDTH      = STATE_WIDTH + 2;
    localparam int ACC_WIDTH       = STATE_WIDTH + 4;
    localparam int ACC_SPLIT       = 16;
    localparam int FIN_WIDTH       = PROD_WIDTH + 2;
    localparam int IN_SHIFT        = SAMPLE_WIDTH - 1 + COEF_FRAC - STATE_FRAC_BITS;
    localparam int OUT_SHIFT       = COEF_FRAC + STATE_FRAC_BITS - OUT_FRAC;

    // step codes; below OP_DIRECT: bits [3:1] pick the section, bit 0 selects input term
    typedef logic [3:0] t_op;
    localparam t_op OP_DIRECT  = 4'd12;
    localparam t_op OP_DELAY   = 4'd13;
    localparam t_op OP_GAIN_LO = 4'd14;
    localparam t_op OP_GAIN_HI = 4'd15;

    localparam logic signed [STATE_WIDTH-1:0] DIRECT_COEF = 32'sd575740366;
    localparam logic signed [STATE_WIDTH-1:0] DELAY_COEF  = 32'sd124474595;
    localparam logic signed [STATE_WIDTH-1:0] OUT_GAIN    = 32'sd118111601;

    typedef struct packed {
        logic load;
        logic mul_en;
        t_op  mul_op;
        logic use_en;
        t_op  use_op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

    function automatic logic signed [STATE_WIDTH-1:0] pole_coef(
        input logic [SEC_IDX_W-1:0] idx
    );
        case (idx)
            3'd0:    return 32'sd1072517758;
            3'd1:    return 32'sd1066569229;
            3'd2:    return 32'sd1040455827;
            3'd3:    return 32'sd930397290;
            3'd4:    return 32'sd590558003;
            3'd5:    return -32'sd817761773;
            default: return '0;
        endcase
    endfunction

    // section five is subtracted, hence the negative gain
    function automatic logic signed [STATE_WIDTH-1:0] in_coef(
        input logic [SEC_IDX_W-1:0] idx
    );
        case (idx)
            3'd0:    return 32'sd59611891;
            3'd1:    return 32'sd80612134;
            3'd2:    return 32'sd165197327;
            3'd3:    return 32'sd333381374;
            3'd4:    return 32'sd572253067;
            3'd5:    return -32'sd18144089;
            default: return '0;
        endcase
    endfunction

    // add half, then arithmetic shift right (round half up)
    function automatic logic signed [PROD_WIDTH-1:0] round_shift(
        input logic signed [PROD_WIDTH-1:0] p,
        input int unsigned                  s
    );
        logic signed [PROD_WIDTH-1:0] half;
        half = {{(PROD_WIDTH-1){1'b0}}, 1'b1} << (s - 1);
        return (p + half) >>> s;
    endfunction

    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [TERM_WIDTH-1:0] v
    );
        logic [TERM_WIDTH-STATE_WIDTH:0] top;
        top = v[TERM_WIDTH-1:STATE_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[STATE_WIDTH-1:0];
        end
        return v[TERM_WIDTH-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                               : {1'b0, {(STATE_WIDTH-1){1'b1}}};
    endfunction

endpackage

### src/pnsf_ctrl.sv
// Step sequencer for the pink noise filter: input handshake, multiply schedule, emit.
// Depends on pnsf_pkg; drives pnsf_datapath through t_cmd.
module pnsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_stall,
    input  pnsf_pkg::t_status i_status,
    output pnsf_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_EMIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    pnsf_pkg::t_op r_step, n_step;
    logic          r_use_vld;
    pnsf_pkg::t_op r_use_op;
    pnsf_pkg::t_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        cmd         = '0;
        cmd.use_en  = r_use_vld;
        cmd.use_op  = r_use_op;
        cmd.mul_op  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_step   = '0;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                cmd.mul_en = 1'b1;
                n_step     = r_step + 4'd1;
                if (r_step == pnsf_pkg::OP_GAIN_HI) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_full || !i_stall) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_use_vld <= 1'b0;
            r_use_op  <= '0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_use_vld <= cmd.mul_en;
            r_use_op  <= r_step;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

endmodule

### src/pnsf_datapath.sv
// Datapath of the pink noise filter: section state, shared multiplier, accumulators,
// output register. Depends on pnsf_pkg; commanded by pnsf_ctrl.
module pnsf_datapath (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  pnsf_pkg::t_cmd                              i_cmd,
    input  logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0]    i_white_sample,
    input  logic                                        i_stall,
    output pnsf_pkg::t_status                           o_status,
    output logic                                        o_valid,
    output logic signed [pnsf_pkg::OUT_WIDTH-1:0]       o_pink_sample
);

    localparam logic signed [pnsf_pkg::FIN_WIDTH-1:0] FIN_HALF =
        {{(pnsf_pkg::FIN_WIDTH-1){1'b0}}, 1'b1} << (pnsf_pkg::OUT_SHIFT - 1);

    logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] r_n;
    logic signed [pnsf_pkg::STATE_WIDTH-1:0]  r_sec [pnsf_pkg::NUM_SECTIONS];
    logic signed [pnsf_pkg::STATE_WIDTH-1:0]  r_delay;
    logic signed [pnsf_pkg::PROD_WIDTH-1:0]   r_prod;
    logic signed [pnsf_pkg::TERM_WIDTH-1:0]   r_fb;
    logic signed [pnsf_pkg::ACC_WIDTH-1:0]    r_acc;
    logic signed [pnsf_pkg::FIN_WIDTH-1:0]    r_fin;
    logic                                     r_out_vld;
    logic signed [pnsf_pkg::OUT_WIDTH-1:0]    r_out;

    logic [pnsf_pkg::SEC_IDX_W-1:0]          mul_idx, use_idx;
    logic signed [pnsf_pkg::STATE_WIDTH-1:0] n_ext, sec_rd, mul_a, mul_b;
    logic signed [pnsf_pkg::PROD_WIDTH-1:0]  prod;
    logic signed [pnsf_pkg::TERM_WIDTH-1:0]  fb_t, in_t;
    logic signed [pnsf_pkg::STATE_WIDTH-1:0] sec_new;
    logic signed [pnsf_pkg::FIN_WIDTH-1:0]   y_full;
    logic signed [pnsf_pkg::OUT_WIDTH-1:0]   y_sat;
    logic [pnsf_pkg::FIN_WIDTH-pnsf_pkg::OUT_WIDTH:0] y_top;

    assign mul_idx = i_cmd.mul_op[3:1];
    assign use_idx = i_cmd.use_op[3:1];
    assign n_ext   = pnsf_pkg::STATE_WIDTH'(r_n);
    assign sec_rd  = (mul_idx < pnsf_pkg::SEC_IDX_W'(pnsf_pkg::NUM_SECTIONS))
                   ? r_sec[mul_idx] : '0;

    always_comb begin
        case (i_cmd.mul_op)
            pnsf_pkg::OP_DIRECT: begin
                mul_a = n_ext;
                mul_b = pnsf_pkg::DIRECT_COEF;
            end
            pnsf_pkg::OP_DELAY: begin
                mul_a = n_ext;
                mul_b = pnsf_pkg::DELAY_COEF;
            end
            pnsf_pkg::OP_GAIN_LO: begin
                mul_a = pnsf_pkg::STATE_WIDTH'({1'b0, r_acc[pnsf_pkg::ACC_SPLIT-1:0]});
                mul_b = pnsf_pkg::OUT_GAIN;
            end
            pnsf_pkg::OP_GAIN_HI: begin
                mul_a = pnsf_pkg::STATE_WIDTH'(
                    signed'(r_acc[pnsf_pkg::ACC_WIDTH-1:pnsf_pkg::ACC_SPLIT]));
                mul_b = pnsf_pkg::OUT_GAIN;
            end
            default: begin
                if (i_cmd.mul_op[0]) begin
                    mul_a = n_ext;
                    mul_b = pnsf_pkg::in_coef(mul_idx);
                end else begin
                    mul_a = sec_rd;
                    mul_b = pnsf_pkg::pole_coef(mul_idx);
                end
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign fb_t    = pnsf_pkg::TERM_WIDTH'(pnsf_pkg::round_shift(r_prod, pnsf_pkg::COEF_FRAC));
    assign in_t    = pnsf_pkg::TERM_WIDTH'(pnsf_pkg::round_shift(r_prod, pnsf_pkg::IN_SHIFT));
    assign sec_new = pnsf_pkg::sat_state(r_fb + in_t);

    // output scaling: r_fin already holds acc * gain plus half an output step
    assign y_full = r_fin >>> pnsf_pkg::OUT_SHIFT;
    assign y_top  = y_full[pnsf_pkg::FIN_WIDTH-1:pnsf_pkg::OUT_WIDTH-1];
    always_comb begin
        if ((&y_top) || !(|y_top)) begin
            y_sat = y_full[pnsf_pkg::OUT_WIDTH-1:0];
        end else if (y_full[pnsf_pkg::FIN_WIDTH-1]) begin
            y_sat = {1'b1, {(pnsf_pkg::OUT_WIDTH-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(pnsf_pkg::OUT_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pnsf_pkg::NUM_SECTIONS; i++) begin
                r_sec[i] <= '0;
            end
            r_delay   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_n   <= i_white_sample;
                r_acc <= pnsf_pkg::ACC_WIDTH'(r_delay);
            end
            if (i_cmd.mul_en) begin
                r_prod <= prod;
            end
            if (i_cmd.use_en) begin
                case (i_cmd.use_op)
                    pnsf_pkg::OP_DIRECT: begin
                        r_acc <= r_acc + pnsf_pkg::ACC_WIDTH'(in_t);
                    end
                    pnsf_pkg::OP_DELAY: begin
                        r_delay <= pnsf_pkg::sat_state(in_t);
                    end
                    pnsf_pkg::OP_GAIN_LO: begin
                        r_fin <= pnsf_pkg::FIN_WIDTH'(r_prod) + FIN_HALF;
                    end
                    pnsf_pkg::OP_GAIN_HI: begin
                        r_fin <= r_fin + (pnsf_pkg::FIN_WIDTH'(r_prod) <<< pnsf_pkg::ACC_SPLIT);
                    end
                    default: begin
                        if (i_cmd.use_op[0]) begin
                            r_sec[use_idx] <= sec_new;
                            r_acc          <= r_acc + pnsf_pkg::ACC_WIDTH'(sec_new);
                        end else begin
                            r_fb <= fb_t;
                        end
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
                r_out     <= y_sat;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.out_full = r_out_vld;
    assign o_valid           = r_out_vld;
    assign o_pink_sample     = r_out;

endmodule

### src/pink_noise_shaping_filter.sv
// Top level of the pink noise filter: joins the sequencer and the datapath.
// Depends on pnsf_pkg, pnsf_ctrl and pnsf_datapath.
//
// Input channel: i_valid / o_stall with i_white_sample (signed Q1.15). A beat is
// taken when i_valid is high and o_stall is low. Output channel: o_valid / i_stall
// with o_pink_sample (signed Q4.15, saturated).
// Each sample runs sixteen multiplies through one shared 32x32 multiplier, one per
// cycle: two per pole section, the direct and delayed input terms, and the output
// gain in two halves. After the multiply schedule the sequencer passes through its
// emit and done states, then loads the result into the output register; o_stall is
// high for all of that, so a new sample is taken only once the last one is emitted.
// The output register decouples the two sides: a new sample is taken while an
// earlier result still waits. If the receiver stalls longer than one sample time,
// the finished sample holds in the datapath and o_stall stays high until the
// output register frees up.
// Synchronous active-low reset clears the section state, the delayed term and the
// output valid; the block is ready for a sample right after reset.
module pink_noise_shaping_filter (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] i_white_sample,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [pnsf_pkg::OUT_WIDTH-1:0]    o_pink_sample
);

    pnsf_pkg::t_cmd    cmd;
    pnsf_pkg::t_status status;

    pnsf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pnsf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_white_sample (i_white_sample),
        .i_stall        (i_stall),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_pink_sample  (o_pink_sample)
    );

endmodule

### src/pnsf_checker.sv
// Port-level checks for the pink noise filter, bound to the top level.
// Depends on pink_noise_shaping_filter_defines.svh and pnsf_pkg.
`include "pink_noise_shaping_filter_defines.svh"

module pnsf_checker (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     i_valid,
    input logic                                     o_stall,
    input logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] i_white_sample,
    input logic                                     o_valid,
    input logic                                     i_stall,
    input logic signed [pnsf_pkg::OUT_WIDTH-1:0]    o_pink_sample
);

    // a taken sample keeps the input closed at the first and the last step of the multiply schedule
    `PNSF_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_valid && !o_stall, o_stall ##15 o_stall, "input reopened early")

    // a new result only comes out of a sample in flight
    `PNSF_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result without work")

    // a stalled result beat holds
    `PNSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pink_sample), "stalled result changed")

    // a stalled input beat holds
    `PNSF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_white_sample), "stalled input changed")

endmodule

bind pink_noise_shaping_filter pnsf_checker u_pnsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_white_sample (i_white_sample),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pink_sample  (o_pink_sample)
);
